@@ rtl/cau_pkg.sv @@
package cau_pkg;

  localparam int DW        = 16;
  localparam int FB        = 12;
  localparam int NCELLS    = 16;
  localparam int CIDX_W    = 4;
  localparam int CW        = 44;
  localparam int ZW        = 34;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_NEG   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_MAG   = 3'd5;
  localparam logic [2:0] OP_PHASE = 3'd6;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [DW-1:0]    pre_re;
    logic signed [DW-1:0]    pre_im;
    logic                    pre_sat;
    logic                    dz;
    logic                    ovf_re;
    logic                    ovf_im;
    logic                    neg_re;
    logic                    neg_im;
    logic [31:0]             den;
    logic [3:0]              mlo_re;
    logic [3:0]              mlo_im;
    logic [31:0]             r_re;
    logic [31:0]             r_im;
    logic [15:0]             q_re;
    logic [15:0]             q_im;
    logic [31:0]             sv;
    logic [17:0]             srem;
    logic [15:0]             root;
    logic                    cskip;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ZW-1:0]    z;
  } cau_cell_t;

  // round(atan(2^-k) * 2^30)
  function automatic logic [29:0] atan_q30(input logic [CIDX_W-1:0] k);
    logic [29:0] r;
    unique case (k)
      4'd0:    r = 30'd843314857;
      4'd1:    r = 30'd497837829;
      4'd2:    r = 30'd263043837;
      4'd3:    r = 30'd133525159;
      4'd4:    r = 30'd67021687;
      4'd5:    r = 30'd33543516;
      4'd6:    r = 30'd16775851;
      4'd7:    r = 30'd8388437;
      4'd8:    r = 30'd4194283;
      4'd9:    r = 30'd2097149;
      4'd10:   r = 30'd1048576;
      4'd11:   r = 30'd524288;
      4'd12:   r = 30'd262144;
      4'd13:   r = 30'd131072;
      4'd14:   r = 30'd65536;
      default: r = 30'd32768;
    endcase
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sat16(input logic signed [35:0] v);
    logic signed [DW-1:0] r;
    if (v > 36'sd32767) r = 16'sh7fff;
    else if (v < -36'sd32768) r = 16'sh8000;
    else r = v[DW-1:0];
    return r;
  endfunction

  function automatic logic ovf16(input logic signed [35:0] v);
    return (v > 36'sd32767) || (v < -36'sd32768);
  endfunction

endpackage

@@ rtl/cau_front.sv @@
module cau_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     go,
  input  logic [2:0]               op,
  input  logic signed [15:0]       a_re,
  input  logic signed [15:0]       a_im,
  input  logic signed [15:0]       b_re,
  input  logic signed [15:0]       b_im,
  input  logic                     go_next,
  output logic                     valid_out,
  output cau_pkg::cau_cell_t       cell_out
);
  import cau_pkg::*;

  logic                 v1, v2, go1, go2, go3;
  logic [2:0]           op1, op2;
  logic signed [15:0]   ar1, ai1, br1, bi1, ar2, ai2;
  logic signed [16:0]   pre17_re, pre17_im, p2_re, p2_im;
  logic signed [31:0]   pp_rr, pp_ii, pp_ri, pp_ir;
  logic [31:0]          sq_br, sq_bi, sq_ar, sq_ai;

  logic signed [33:0]   mre_s, mim_s, nre, nim;
  logic [33:0]          mag_re, mag_im;
  logic [31:0]          den;
  logic signed [15:0]   mul_re, mul_im;
  logic                 neg_a;
  logic signed [16:0]   xr, yr;
  cau_cell_t            c_next;

  assign go3 = !valid_out || go_next;
  assign go2 = !v2 || go3;
  assign go1 = !v1 || go2;
  assign go  = go1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (go1) begin
      v1 <= in_valid;
    end
    if (go1) begin
      op1 <= op;
      ar1 <= a_re;
      ai1 <= a_im;
      br1 <= b_re;
      bi1 <= b_im;
    end
  end

  always_comb begin
    unique case (op1)
      OP_ADD: begin
        pre17_re = 17'(ar1) + 17'(br1);
        pre17_im = 17'(ai1) + 17'(bi1);
      end
      OP_SUB: begin
        pre17_re = 17'(ar1) - 17'(br1);
        pre17_im = 17'(ai1) - 17'(bi1);
      end
      OP_NEG: begin
        pre17_re = -17'(ar1);
        pre17_im = -17'(ai1);
      end
      default: begin
        pre17_re = '0;
        pre17_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (go2) begin
      v2 <= v1;
    end
    if (go2) begin
      op2   <= op1;
      ar2   <= ar1;
      ai2   <= ai1;
      p2_re <= pre17_re;
      p2_im <= pre17_im;
      pp_rr <= ar1 * br1;
      pp_ii <= ai1 * bi1;
      pp_ri <= ar1 * bi1;
      pp_ir <= ai1 * br1;
      sq_br <= 32'(br1 * br1);
      sq_bi <= 32'(bi1 * bi1);
      sq_ar <= 32'(ar1 * ar1);
      sq_ai <= 32'(ai1 * ai1);
    end
  end

  always_comb begin
    mre_s  = 34'(pp_rr) - 34'(pp_ii) + 34'sd2048;
    mim_s  = 34'(pp_ri) + 34'(pp_ir) + 34'sd2048;
    mul_re = sat16(36'(mre_s >>> FB));
    mul_im = sat16(36'(mim_s >>> FB));
    den    = sq_br + sq_bi;
    nre    = 34'(pp_rr) + 34'(pp_ii);
    nim    = 34'(pp_ir) - 34'(pp_ri);
    mag_re = (nre < 0) ? 34'(-nre) : 34'(nre);
    mag_im = (nim < 0) ? 34'(-nim) : 34'(nim);
    neg_a  = ar2 < 0;
    xr     = neg_a ? -17'(ar2) : 17'(ar2);
    yr     = neg_a ? -17'(ai2) : 17'(ai2);

    c_next        = '0;
    c_next.op     = op2;
    if (op2 == OP_MUL) begin
      c_next.pre_re  = mul_re;
      c_next.pre_im  = mul_im;
      c_next.pre_sat = ovf16(36'(mre_s >>> FB)) || ovf16(36'(mim_s >>> FB));
    end else begin
      c_next.pre_re  = sat16(36'(p2_re));
      c_next.pre_im  = sat16(36'(p2_im));
      c_next.pre_sat = ovf16(36'(p2_re)) || ovf16(36'(p2_im));
    end
    c_next.dz     = den == '0;
    c_next.den    = den;
    c_next.neg_re = nre < 0;
    c_next.neg_im = nim < 0;
    c_next.ovf_re = {2'b00, mag_re} >= {den, 4'b0000};
    c_next.ovf_im = {2'b00, mag_im} >= {den, 4'b0000};
    c_next.mlo_re = mag_re[3:0];
    c_next.mlo_im = mag_im[3:0];
    c_next.r_re   = 32'(mag_re >> 4);
    c_next.r_im   = 32'(mag_im >> 4);
    c_next.sv     = sq_ar + sq_ai;
    c_next.cskip  = ai2 == '0;
    c_next.x      = {{3{xr[16]}}, xr, 24'd0};
    c_next.y      = {{3{yr[16]}}, yr, 24'd0};
    if (ai2 == '0) begin
      c_next.z = neg_a ? PI_Q30 : '0;
    end else if (neg_a) begin
      c_next.z = (ai2 > 0) ? PI_Q30 : -PI_Q30;
    end else begin
      c_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (go3) begin
      valid_out <= v2;
    end
    if (go3) begin
      cell_out <= c_next;
    end
  end

endmodule

@@ rtl/cau_cell.sv @@
module cau_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [3:0]               idx,
  input  logic                     valid_in,
  input  cau_pkg::cau_cell_t       d_in,
  input  logic                     go_next,
  output logic                     go,
  output logic                     valid_out,
  output cau_pkg::cau_cell_t       d_out
);
  import cau_pkg::*;

  cau_cell_t            nx;
  logic                 nb_re, nb_im;
  logic [32:0]          t_re, t_im;
  logic [19:0]          st, trial;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at;

  assign go = !valid_out || go_next;

  always_comb begin
    nx    = d_in;
    nb_re = (idx <= 4'd3) ? d_in.mlo_re[~idx[1:0]] : 1'b0;
    nb_im = (idx <= 4'd3) ? d_in.mlo_im[~idx[1:0]] : 1'b0;
    t_re  = {d_in.r_re, nb_re};
    t_im  = {d_in.r_im, nb_im};
    if (t_re >= {1'b0, d_in.den}) begin
      nx.r_re = 32'(t_re - {1'b0, d_in.den});
      nx.q_re = {d_in.q_re[14:0], 1'b1};
    end else begin
      nx.r_re = t_re[31:0];
      nx.q_re = {d_in.q_re[14:0], 1'b0};
    end
    if (t_im >= {1'b0, d_in.den}) begin
      nx.r_im = 32'(t_im - {1'b0, d_in.den});
      nx.q_im = {d_in.q_im[14:0], 1'b1};
    end else begin
      nx.r_im = t_im[31:0];
      nx.q_im = {d_in.q_im[14:0], 1'b0};
    end

    st    = {d_in.srem, d_in.sv[{~idx, 1'b0} +: 2]};
    trial = {2'b00, d_in.root, 2'b01};
    if (st >= trial) begin
      nx.srem = 18'(st - trial);
      nx.root = {d_in.root[14:0], 1'b1};
    end else begin
      nx.srem = st[17:0];
      nx.root = {d_in.root[14:0], 1'b0};
    end

    xs = d_in.x >>> idx;
    ys = d_in.y >>> idx;
    at = $signed({4'b0000, atan_q30(idx)});
    if (!d_in.cskip) begin
      if (d_in.y > 0) begin
        nx.x = d_in.x + ys;
        nx.y = d_in.y - xs;
        nx.z = d_in.z + at;
      end else begin
        nx.x = d_in.x - ys;
        nx.y = d_in.y + xs;
        nx.z = d_in.z - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (go) begin
      valid_out <= valid_in;
    end
    if (go) begin
      d_out <= nx;
    end
  end

endmodule

@@ rtl/cau_back.sv @@
module cau_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid_in,
  input  cau_pkg::cau_cell_t       d_in,
  output logic                     go,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       res_re,
  output logic signed [15:0]       res_im,
  output logic [1:0]               status
);
  import cau_pkg::*;

  logic signed [15:0]   n_re, n_im;
  logic [1:0]           n_st;
  logic signed [16:0]   qv_re, qv_im;
  logic signed [33:0]   zr;
  logic                 s_re, s_im;

  assign go = !out_valid || !out_stall;

  always_comb begin
    qv_re = d_in.neg_re ? -$signed({1'b0, d_in.q_re}) : $signed({1'b0, d_in.q_re});
    qv_im = d_in.neg_im ? -$signed({1'b0, d_in.q_im}) : $signed({1'b0, d_in.q_im});
    zr    = (d_in.z + 34'sd131072) >>> (30 - FB);
    n_re  = '0;
    n_im  = '0;
    n_st  = ST_OK;
    s_re  = 1'b0;
    s_im  = 1'b0;
    unique case (d_in.op)
      OP_ADD, OP_SUB, OP_NEG, OP_MUL: begin
        n_re = d_in.pre_re;
        n_im = d_in.pre_im;
        n_st = d_in.pre_sat ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (d_in.dz) begin
          n_st = ST_DZ;
        end else begin
          if (d_in.ovf_re) begin
            n_re = d_in.neg_re ? 16'sh8000 : 16'sh7fff;
            s_re = 1'b1;
          end else begin
            n_re = sat16(36'(qv_re));
            s_re = ovf16(36'(qv_re));
          end
          if (d_in.ovf_im) begin
            n_im = d_in.neg_im ? 16'sh8000 : 16'sh7fff;
            s_im = 1'b1;
          end else begin
            n_im = sat16(36'(qv_im));
            s_im = ovf16(36'(qv_im));
          end
          n_st = (s_re || s_im) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        n_re = sat16(36'($signed({1'b0, d_in.root})));
        n_st = ovf16(36'($signed({1'b0, d_in.root}))) ? ST_SAT : ST_OK;
      end
      OP_PHASE: begin
        n_re = sat16(36'(zr));
        n_st = ovf16(36'(zr)) ? ST_SAT : ST_OK;
      end
      default: begin
        n_re = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= valid_in;
    end
    if (go) begin
      res_re <= n_re;
      res_im <= n_im;
      status <= n_st;
    end
  end

endmodule

@@ rtl/complex_arith_unit.sv @@
// Complex ALU on signed Q3.12 operands: add, sub, negate, multiply, divide,
// magnitude and phase (radians, Q3.12).
// Input channel: in_valid/in_stall with op, a_re, a_im, b_re, b_im. A
// transaction is taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with res_re, res_im, status; one
// result transaction per input transaction, in order.
// The pipeline is an input register, a multiplier stage, a setup stage,
// a row of 16 cells and the output register. Each cell does one restoring
// divide step for both quotient parts, one square root digit and one CORDIC
// rotation, so the row accepts one transaction per cycle when not stalled.
// When out_stall is high the result holds; stages behind it keep filling
// until every stage holds a transaction, and only then is in_stall raised.
// Reset (rst, synchronous) empties the pipeline; no results are pending.
module complex_arith_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [15:0] a_re,
  input  logic signed [15:0] a_im,
  input  logic signed [15:0] b_re,
  input  logic signed [15:0] b_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] res_re,
  output logic signed [15:0] res_im,
  output logic [1:0]         status
);
  import cau_pkg::*;

  cau_cell_t  chain_d  [0:NCELLS];
  logic       chain_v  [0:NCELLS];
  logic       chain_go [0:NCELLS];
  logic       front_go;

  assign in_stall = !front_go;

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .go        (front_go),
    .op        (op),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .go_next   (chain_go[0]),
    .valid_out (chain_v[0]),
    .cell_out  (chain_d[0])
  );

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    cau_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (CIDX_W'(k)),
      .valid_in  (chain_v[k]),
      .d_in      (chain_d[k]),
      .go_next   (chain_go[k+1]),
      .go        (chain_go[k]),
      .valid_out (chain_v[k+1]),
      .d_out     (chain_d[k+1])
    );
  end

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (chain_v[NCELLS]),
    .d_in      (chain_d[NCELLS]),
    .go        (chain_go[NCELLS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_re    (res_re),
    .res_im    (res_im),
    .status    (status)
  );

endmodule
